FILE: sv/sat_pkg.sv
// Shared types and codes for the sorted array table.
// Used by sat_cell and sorted_array_table_core; depends on nothing.
package sat_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int OP_W   = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 6;
    localparam int IDXO_W = 7;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_ADD        = 3'd0;
    localparam logic [OP_W-1:0] OP_GET        = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_AT  = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_ALL = 3'd3;
    localparam logic [OP_W-1:0] OP_INDEX_OF   = 3'd4;
    localparam logic [OP_W-1:0] OP_CONTAINS   = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    localparam logic [IDXO_W-1:0] IDX_NONE = 7'h7F;

    // cell actions
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_DELPOS = 2'd2;
    localparam logic [1:0] CELL_DELLB  = 2'd3;

    typedef struct packed {
        logic [1:0] act;   // what the cell does with its entry
        logic       cmp;   // capture compare flags against the request value
    } t_cell_ctl;

endpackage

FILE: sv/sat_cell.sv
// One cell of the sorted store: holds a single entry and its compare flags.
// Depends on sat_pkg; instantiated in a row by sorted_array_table_core.
module sat_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                          i_clk,
    input  sat_pkg::t_cell_ctl            i_ctl,
    input  logic [sat_pkg::VAL_W-1:0]     i_value,
    input  logic [CW-1:0]                 i_count,
    input  logic [sat_pkg::POS_W-1:0]     i_pos,
    input  logic [sat_pkg::VAL_W-1:0]     i_prev_entry,
    input  logic                          i_prev_lt,
    input  logic [sat_pkg::VAL_W-1:0]     i_next_entry,
    output logic [sat_pkg::VAL_W-1:0]     o_entry,
    output logic                          o_lt,
    output logic                          o_hit
);

    localparam logic [31:0] IDX_W32 = 32'(IDX);

    logic [sat_pkg::VAL_W-1:0] r_entry, n_entry;
    logic                      r_lt, r_eq;
    logic                      in_use, ge_pos;

    assign in_use = i_count > CW'(IDX);
    assign ge_pos = IDX_W32 >= {26'd0, i_pos};

    always_comb begin
        unique case (i_ctl.act)
            sat_pkg::CELL_HOLD:   n_entry = r_entry;
            // keep below the slot, drop the value in, push the rest up
            sat_pkg::CELL_INSERT: n_entry = r_lt ? r_entry :
                                            (i_prev_lt ? i_value : i_prev_entry);
            sat_pkg::CELL_DELPOS: n_entry = ge_pos ? i_next_entry : r_entry;
            sat_pkg::CELL_DELLB:  n_entry = r_lt ? r_entry : i_next_entry;
            default:              n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_ctl.cmp) begin
            r_lt <= in_use && ($signed(r_entry) < $signed(i_value));
            r_eq <= in_use && (r_entry == i_value);
        end
    end

    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    // first entry not below the value, and equal to it
    assign o_hit   = r_eq && !r_lt && i_prev_lt;

endmodule

FILE: sv/sorted_array_table_core.sv
// Sorted array table: a row of DEPTH cells keeps signed words in ascending order.
// Steps: compare, then act, then a registered result; remove-all loops back to compare
// for each removed copy. A new request is taken only while idle; busy is high while working.
// Each request gives one result word on o_done for one cycle; the receiver cannot stall.
// Reset (synchronous, active low) empties the table; entry contents stay undefined.
// Depends on sat_pkg and sat_cell.
module sorted_array_table_core #(
    parameter int DEPTH = sat_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [sat_pkg::OP_W-1:0]           i_operation,
    input  logic signed [sat_pkg::VAL_W-1:0]   i_value,
    input  logic [sat_pkg::POS_W-1:0]          i_position,
    output logic                               o_done,
    output logic signed [sat_pkg::VAL_W-1:0]   o_data,
    output logic signed [sat_pkg::IDXO_W-1:0]  o_first_index,
    output logic                               o_found,
    output logic [sat_pkg::ST_W-1:0]           o_status,
    output logic [sat_pkg::IDXO_W-1:0]         o_count,
    output logic                               o_empty_res
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // controller states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_ACT  = 2'd2;

    logic [1:0] r_state, n_state;

    // latched request
    logic [sat_pkg::OP_W-1:0]  r_op;
    logic [sat_pkg::VAL_W-1:0] r_value;
    logic [sat_pkg::POS_W-1:0] r_pos;

    logic [CW-1:0] r_count, n_count;

    // result register
    logic                        r_done, n_done;
    logic [sat_pkg::VAL_W-1:0]   r_data, n_data;
    logic [sat_pkg::IDXO_W-1:0]  r_first, n_first;
    logic                        r_found, n_found;
    logic [sat_pkg::ST_W-1:0]    r_status, n_status;
    logic [sat_pkg::IDXO_W-1:0]  r_count_o, n_count_o;
    logic                        r_empty, n_empty;

    // cell row
    sat_pkg::t_cell_ctl        cell_ctl;
    logic [sat_pkg::VAL_W-1:0] w_entry [DEPTH];
    logic                      w_lt    [DEPTH];
    logic                      w_hit   [DEPTH];

    logic                      any_hit;
    logic [IW-1:0]             hit_idx;
    logic [IW+5:0]             pos_wide;
    logic [sat_pkg::VAL_W-1:0] pos_entry;
    logic                      pos_ok;
    logic                      full;

    // Row of cells: each takes from its left neighbor on insert and from its
    // right neighbor on delete. Cell 0 sees a "less than" flag of one on its left.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sat_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_value      (r_value),
            .i_count      (r_count),
            .i_pos        (r_pos),
            .i_prev_entry ((g == 0) ? r_value : w_entry[(g == 0) ? 0 : g-1]),
            .i_prev_lt    ((g == 0) ? 1'b1 : w_lt[(g == 0) ? 0 : g-1]),
            .i_next_entry ((g == DEPTH-1) ? w_entry[g] : w_entry[(g == DEPTH-1) ? g : g+1]),
            .o_entry      (w_entry[g]),
            .o_lt         (w_lt[g]),
            .o_hit        (w_hit[g])
        );
    end

    // At most one cell reports a hit: the lower bound of the value, if equal.
    always_comb begin
        any_hit = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            any_hit = any_hit | w_hit[i];
            hit_idx = hit_idx | (w_hit[i] ? IW'(i) : '0);
        end
    end

    // Position read for get and remove-at; a legal position is below count.
    assign pos_wide  = {{IW{1'b0}}, r_pos};
    assign pos_entry = w_entry[pos_wide[IW-1:0]];
    assign pos_ok    = {26'd0, r_pos} < 32'(r_count);
    assign full      = r_count == CW'(DEPTH);

    assign busy = r_state != S_IDLE;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        cell_ctl.act = sat_pkg::CELL_HOLD;
        cell_ctl.cmp = 1'b0;
        n_done       = 1'b0;
        n_data       = '0;
        n_first      = '0;
        n_found      = 1'b0;
        n_status     = sat_pkg::ST_OK;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                // capture compare flags in every cell
                cell_ctl.cmp = 1'b1;
                n_state      = S_ACT;
            end
            S_ACT: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                unique case (r_op)
                    sat_pkg::OP_ADD: begin
                        if (full) begin
                            n_status = sat_pkg::ST_FULL;
                        end else begin
                            cell_ctl.act = sat_pkg::CELL_INSERT;
                            n_count      = r_count + CW'(1);
                        end
                    end
                    sat_pkg::OP_GET: begin
                        if (pos_ok) begin
                            n_data = pos_entry;
                        end else begin
                            n_status = sat_pkg::ST_RANGE;
                        end
                    end
                    sat_pkg::OP_REMOVE_AT: begin
                        if (pos_ok) begin
                            n_data       = pos_entry;
                            cell_ctl.act = sat_pkg::CELL_DELPOS;
                            n_count      = r_count - CW'(1);
                        end else begin
                            n_status = sat_pkg::ST_RANGE;
                        end
                    end
                    sat_pkg::OP_REMOVE_ALL: begin
                        // drop one copy per pass, then compare again
                        if (any_hit) begin
                            cell_ctl.act = sat_pkg::CELL_DELLB;
                            n_count      = r_count - CW'(1);
                            n_state      = S_CMP;
                            n_done       = 1'b0;
                        end
                    end
                    sat_pkg::OP_INDEX_OF: begin
                        n_found = any_hit;
                        n_first = any_hit ? sat_pkg::IDXO_W'(hit_idx) : sat_pkg::IDX_NONE;
                    end
                    sat_pkg::OP_CONTAINS: begin
                        n_found = any_hit;
                    end
                    sat_pkg::OP_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_count_o = sat_pkg::IDXO_W'(n_count);
        n_empty   = n_count == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // hold the request while working
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op    <= i_operation;
            r_value <= i_value;
            r_pos   <= i_position;
        end
        r_data    <= n_data;
        r_first   <= n_first;
        r_found   <= n_found;
        r_status  <= n_status;
        r_count_o <= n_count_o;
        r_empty   <= n_empty;
    end

    assign o_done        = r_done;
    assign o_data        = r_data;
    assign o_first_index = r_first;
    assign o_found       = r_found;
    assign o_status      = r_status;
    assign o_count       = r_count_o;
    assign o_empty_res   = r_empty;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while still working");

    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_empty_res == (r_count == '0)))
        else $error("empty flag disagrees with count");
`endif

endmodule

FILE: tb/tb_sorted_array_table_core.sv
// Self-checking testbench for sorted_array_table_core: ordered insert, get, remove,
// search and clear words checked against a shadow copy of the sorted table.
// Depends on sat_pkg and the sorted_array_table_core RTL; reads no files.
module tb_sorted_array_table_core;

    // Operation code 7 is not decoded by the block; it must answer with count and empty flag only.
    localparam logic [sat_pkg::OP_W-1:0] OP_NOP = 3'd7;

    // Random part: number of request words and the flavors of traffic phases.
    localparam int RANDOM_WORDS = 650;
    localparam int PH_FILL      = 0;
    localparam int PH_DUPS      = 1;
    localparam int PH_MIXED     = 2;
    localparam int PH_DRAIN     = 3;

    // Remove-all loops through compare and act again for each removed copy, so the tail grows with depth.
    localparam int TAIL_CYCLES  = 2 * sat_pkg::DEPTH_DEF + 40;

    typedef struct packed {
        logic signed [sat_pkg::VAL_W-1:0]  data;
        logic signed [sat_pkg::IDXO_W-1:0] first_index;
        logic                              found;
        logic [sat_pkg::ST_W-1:0]          status;
        logic [sat_pkg::IDXO_W-1:0]        count;
        logic                              empty_res;
    } t_sat_reply;

    // Shadow of the sorted table plus the replies it owes, oldest first.
    class sat_table_shadow;
        logic signed [sat_pkg::VAL_W-1:0] rows[$];
        t_sat_reply                       replies_due[$];
        int unsigned                      mismatches;
        int unsigned                      replies_seen;

        // Apply one accepted request word to the shadow table and queue its reply.
        function void note_request(logic [sat_pkg::OP_W-1:0] op,
                                   logic signed [sat_pkg::VAL_W-1:0] val,
                                   logic [sat_pkg::POS_W-1:0] pos);
            t_sat_reply r;
            int         lb;
            r  = '0;
            lb = 0;
            // lowest slot whose entry is not below the request value
            while (lb < rows.size() && rows[lb] < val) lb++;
            case (op)
                sat_pkg::OP_ADD: begin
                    if (rows.size() >= sat_pkg::DEPTH_DEF) r.status = sat_pkg::ST_FULL;
                    else rows.insert(lb, val);
                end
                sat_pkg::OP_GET: begin
                    if (pos >= rows.size()) r.status = sat_pkg::ST_RANGE;
                    else r.data = rows[pos];
                end
                sat_pkg::OP_REMOVE_AT: begin
                    if (pos >= rows.size()) begin
                        r.status = sat_pkg::ST_RANGE;
                    end else begin
                        r.data = rows[pos];
                        rows.delete(pos);
                    end
                end
                sat_pkg::OP_REMOVE_ALL: begin
                    while (lb < rows.size() && rows[lb] == val) rows.delete(lb);
                end
                sat_pkg::OP_INDEX_OF, sat_pkg::OP_CONTAINS: begin
                    if (lb < rows.size() && rows[lb] == val) begin
                        r.found       = 1'b1;
                        r.first_index = 7'(lb);
                    end else begin
                        r.first_index = sat_pkg::IDX_NONE;
                    end
                    if (op == sat_pkg::OP_CONTAINS) r.first_index = '0;
                end
                sat_pkg::OP_CLEAR: begin
                    rows.delete();
                end
                default: begin
                end
            endcase
            r.count     = 7'(rows.size());
            r.empty_res = (rows.size() == 0);
            replies_due.push_back(r);
        endfunction

        // Compare one reply from the block with the oldest one owed.
        function void check_reply(t_sat_reply got);
            t_sat_reply want;
            replies_seen++;
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("reply %0d: none outstanding, got data=%0d count=%0d",
                             replies_seen, got.data, got.count);
                return;
            end
            want = replies_due.pop_front();
            if (got.data != want.data || got.first_index != want.first_index ||
                got.found != want.found || got.status != want.status ||
                got.count != want.count || got.empty_res != want.empty_res) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display({"reply %0d: expected data=%0d first=%0d found=%0b",
                              " st=%0d cnt=%0d emp=%0b"},
                             replies_seen, want.data, want.first_index, want.found,
                             want.status, want.count, want.empty_res);
                    $display({"reply %0d:      got data=%0d first=%0d found=%0b",
                              " st=%0d cnt=%0d emp=%0b"},
                             replies_seen, got.data, got.first_index, got.found,
                             got.status, got.count, got.empty_res);
                end
            end
        endfunction
    endclass

    // Drive every input to a known value from time zero.
    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              start       = 1'b0;
    logic [sat_pkg::OP_W-1:0]          i_operation = '0;
    logic signed [sat_pkg::VAL_W-1:0]  i_value     = '0;
    logic [sat_pkg::POS_W-1:0]         i_position  = '0;
    logic                              busy;
    logic                              o_done;
    logic signed [sat_pkg::VAL_W-1:0]  o_data;
    logic signed [sat_pkg::IDXO_W-1:0] o_first_index;
    logic                              o_found;
    logic [sat_pkg::ST_W-1:0]          o_status;
    logic [sat_pkg::IDXO_W-1:0]        o_count;
    logic                              o_empty_res;

    sat_table_shadow table_sb = new();

    sorted_array_table_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_done        (o_done),
        .o_data        (o_data),
        .o_first_index (o_first_index),
        .o_found       (o_found),
        .o_status      (o_status),
        .o_count       (o_count),
        .o_empty_res   (o_empty_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sample the result strobe at the edge that ends its cycle; the block cannot be held off.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            table_sb.check_reply('{o_data, o_first_index, o_found, o_status,
                                   o_count, o_empty_res});
    end

    // Hard stop in case the block hangs or never drains its replies.
    initial begin
        #10_000_000;
        $display("[sorted_array_table_core] ERROR");
        $finish;
    end

    // Present one word and hold it until an edge sees start high with busy low.
    // Call right after a rising edge; leave start high so back-to-back words need no gap.
    task automatic put_word(input logic [sat_pkg::OP_W-1:0] op,
                            input logic signed [sat_pkg::VAL_W-1:0] val,
                            input logic [sat_pkg::POS_W-1:0] pos);
        start       <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        i_position  <= pos;
        do @(posedge i_clk); while (busy);
        table_sb.note_request(op, val, pos);
    endtask

    // Drop start and wait out the requested gap; zero means keep streaming.
    task automatic hold_off(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Mostly no gap or a short one, now and then a long one.
    function automatic int gap_len(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic put_and_rest(input logic [sat_pkg::OP_W-1:0] op,
                                input logic signed [sat_pkg::VAL_W-1:0] val,
                                input logic [sat_pkg::POS_W-1:0] pos, input bit quiet);
        put_word(op, val, pos);
        hold_off(gap_len(quiet));
    endtask

    // Stop sending until every reply owed has come back.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (table_sb.replies_due.size() != 0);
    endtask

    // Choose an operation; add_pct and rm_pct steer the table toward full or empty.
    function automatic logic [sat_pkg::OP_W-1:0] pick_op(int add_pct, int rm_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < add_pct) return sat_pkg::OP_ADD;
        r = $urandom_range(0, 99);
        if (r < rm_pct / 2) return sat_pkg::OP_REMOVE_AT;
        if (r < rm_pct) return sat_pkg::OP_REMOVE_ALL;
        if (r < 96) begin
            case ($urandom_range(0, 2))
                0: return sat_pkg::OP_GET;
                1: return sat_pkg::OP_INDEX_OF;
                default: return sat_pkg::OP_CONTAINS;
            endcase
        end
        if (r < 98) return sat_pkg::OP_CLEAR;
        return OP_NOP;
    endfunction

    // Values: hit stored entries often so searches and remove-all find something.
    function automatic logic signed [sat_pkg::VAL_W-1:0] pick_value(bit tiny_pool);
        int r;
        int k;
        if (tiny_pool) begin
            k = $urandom_range(0, 3);
            return k - 2;
        end
        r = $urandom_range(0, 99);
        if (r < 25 && table_sb.rows.size() != 0)
            return table_sb.rows[$urandom_range(0, table_sb.rows.size() - 1)];
        if (r < 45) begin
            k = $urandom_range(0, 16);
            return k - 8;
        end
        if (r < 52) begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return '0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    // Positions: mostly inside the table, the rest anywhere in the 6-bit field.
    function automatic logic [sat_pkg::POS_W-1:0] pick_pos();
        if (table_sb.rows.size() != 0 && $urandom_range(0, 3) != 0)
            return sat_pkg::POS_W'($urandom_range(0, table_sb.rows.size() - 1));
        return sat_pkg::POS_W'($urandom_range(0, 63));
    endfunction

    initial begin
        int  sent;
        int  phase;
        int  kind;
        int  len;
        int  add_pct;
        int  rm_pct;
        bit  quiet;
        logic [sat_pkg::OP_W-1:0] op;

        // Hold reset low at start, release it on an edge and never touch it again.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: empty-table corners first.
        put_and_rest(sat_pkg::OP_GET,        32'sd0,         6'd0,  1'b0); // get, empty
        put_and_rest(sat_pkg::OP_REMOVE_AT,  32'sd0,         6'd63, 1'b0); // remove-at, empty
        put_and_rest(sat_pkg::OP_CLEAR,      32'sd0,         6'd0,  1'b0); // clear, empty
        put_and_rest(sat_pkg::OP_REMOVE_ALL, 32'sd5,         6'd0,  1'b0); // value absent
        put_and_rest(OP_NOP,                 -32'sd1,        6'd63, 1'b0); // undecoded op
        // Fill with extremes and a duplicate pair.
        put_and_rest(sat_pkg::OP_ADD,        32'sh7FFF_FFFF, 6'd0,  1'b0);
        put_and_rest(sat_pkg::OP_ADD,        32'sh8000_0000, 6'd0,  1'b0);
        put_and_rest(sat_pkg::OP_ADD,        32'sd0,         6'd0,  1'b0);
        put_and_rest(sat_pkg::OP_ADD,        -32'sd1,        6'd0,  1'b0);
        put_and_rest(sat_pkg::OP_ADD,        -32'sd1,        6'd0,  1'b0);
        put_and_rest(sat_pkg::OP_ADD,        32'sd1,         6'd0,  1'b0);
        // Searches: first copy of a duplicate, the minimum, absent values.
        put_and_rest(sat_pkg::OP_INDEX_OF,   -32'sd1,        6'd0,  1'b0);
        put_and_rest(sat_pkg::OP_CONTAINS,   32'sh8000_0000, 6'd0,  1'b0);
        put_and_rest(sat_pkg::OP_INDEX_OF,   32'sd2,         6'd0,  1'b0);
        put_and_rest(sat_pkg::OP_CONTAINS,   32'sd7,         6'd0,  1'b0);
        // Reads at both ends, just past the end and at the top of the position field.
        put_and_rest(sat_pkg::OP_GET,        32'sd0,         6'd0,  1'b0);
        put_and_rest(sat_pkg::OP_GET,        32'sd0,         6'd5,  1'b0);
        put_and_rest(sat_pkg::OP_GET,        32'sd0,         6'd6,  1'b0);
        put_and_rest(sat_pkg::OP_GET,        32'sd0,         6'd63, 1'b0);
        // Removals: both duplicates at once, an absent value, first and last slot.
        put_and_rest(sat_pkg::OP_REMOVE_ALL, -32'sd1,        6'd0,  1'b0);
        put_and_rest(sat_pkg::OP_REMOVE_ALL, 32'sd2,         6'd0,  1'b0);
        put_and_rest(sat_pkg::OP_REMOVE_AT,  32'sd0,         6'd0,  1'b0);
        put_and_rest(sat_pkg::OP_REMOVE_AT,  32'sd0,         6'd2,  1'b0);
        put_and_rest(OP_NOP,                 32'sd0,         6'd0,  1'b0);
        put_and_rest(sat_pkg::OP_CLEAR,      32'sd0,         6'd0,  1'b0);

        // Random phases: fill to full first, then heavy duplicates, then a random mix.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS) begin
            kind  = (phase < 2) ? phase : $urandom_range(PH_MIXED - 1, PH_DRAIN);
            quiet = ($urandom_range(0, 3) == 0);
            len   = (kind == PH_FILL) ? 90 : $urandom_range(20, 60);
            case (kind)
                PH_FILL:  begin add_pct = 90; rm_pct = 10; end
                PH_DUPS:  begin add_pct = 55; rm_pct = 30; end
                PH_MIXED: begin add_pct = 45; rm_pct = 40; end
                default:  begin add_pct = 15; rm_pct = 70; end
            endcase
            for (int n = 0; n < len && sent < RANDOM_WORDS; n++) begin
                op = pick_op(add_pct, rm_pct);
                put_and_rest(op, pick_value(kind == PH_DUPS), pick_pos(), quiet);
                sent++;
            end
            // Let the block go fully idle after the fill phase and now and then later.
            if (phase == 0 || $urandom_range(0, 2) == 0) wait_drained();
            phase++;
        end

        // Wait for every reply owed, then watch a while longer for strays.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (table_sb.mismatches == 0 && table_sb.replies_due.size() == 0) begin
            $display("[sorted_array_table_core] OK");
        end else begin
            $display("[sorted_array_table_core] ERROR");
        end
        $finish;
    end

endmodule
